@@ src/hcar_pkg.sv @@
`timescale 1ns / 1ps

package hcar_pkg;

    localparam int PHASE_W        = 48;
    localparam int TOW_W          = 31;
    localparam int TOL_W          = 16;
    localparam int LIMIT_W        = 8;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd3277;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd30;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TOL   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_LIMIT = 2'd1;

    localparam logic [1:0] ST_SKIPPED    = 2'd0;
    localparam logic [1:0] ST_NO_TIME    = 2'd1;
    localparam logic [1:0] ST_MISMATCH   = 2'd2;
    localparam logic [1:0] ST_MATCHED    = 2'd3;

    localparam logic [1:0] POL_UNKNOWN   = 2'd0;
    localparam logic [1:0] POL_NORMAL    = 2'd1;
    localparam logic [1:0] POL_INVERTED  = 2'd2;

    typedef struct packed {
        logic                       epoch_valid;
        logic                       freq_locked;
        logic signed [PHASE_W-1:0]  pilot_phase_now;
        logic signed [PHASE_W-1:0]  pilot_phase_prev;
        logic signed [TOW_W-1:0]    pilot_tow_now;
        logic signed [TOW_W-1:0]    pilot_tow_prev;
        logic signed [PHASE_W-1:0]  data_phase_now;
        logic signed [PHASE_W-1:0]  data_phase_prev;
        logic signed [TOW_W-1:0]    data_tow_now;
        logic signed [TOW_W-1:0]    data_tow_prev;
        logic                       partner_present;
        logic                       partner_synced;
    } item_t;

    typedef struct packed {
        logic                drop_request;
        logic [1:0]          check_status;
        logic                resolved;
        logic [1:0]          partner_polarity;
        logic                partner_update;
        logic [LIMIT_W-1:0]  match_count;
    } res_t;

endpackage

@@ src/hcar_in_reg.sv @@
`timescale 1ns / 1ps

module hcar_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  hcar_pkg::item_t in_item,
    input  logic            advance,
    output logic            stall,
    output logic            valid,
    output hcar_pkg::item_t item
);
    import hcar_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign stall      = valid_reg && !advance;
    assign valid_next = stall ? valid_reg : in_valid;
    assign valid      = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // load a new item only when the stage is free
    always_ff @(posedge clk)
    begin
        if (in_valid && !stall)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ src/hcar_eval.sv @@
`timescale 1ns / 1ps

module hcar_eval #(
    parameter int PHASE_FRAC_BITS = hcar_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [hcar_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hcar_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                cfg_ready,
    input  logic                                fire,
    input  hcar_pkg::item_t                     item,
    output hcar_pkg::res_t                      res
);
    import hcar_pkg::*;

    localparam int F     = PHASE_FRAC_BITS;
    localparam int CMP_W = ((F > TOL_W) ? F : TOL_W) + 2;
    localparam logic signed [CMP_W-1:0] HALF = CMP_W'(1) << (F - 1);

    logic [TOL_W-1:0]   tol_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] count_reg;
    logic [LIMIT_W-1:0] count_next;
    logic               sync_reg;
    logic               sync_next;

    logic               tmatch;
    logic [F-1:0]       pa;
    logic [F-1:0]       pb;
    logic [F-1:0]       frac;
    logic [F:0]         other;
    logic [F:0]         cyc_dist;
    logic signed [CMP_W-1:0] metric;
    logic signed [CMP_W-1:0] tol_s;
    logic [1:0]         found;
    logic               drop;
    logic [1:0]         status;
    logic [1:0]         pol;
    logic               upd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PHASE_TOL:   tol_reg   <= cfg_data;
                REG_MATCH_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // pick the first pair of equal time tags
    always_comb
    begin
        tmatch = 1'b1;
        pa     = item.pilot_phase_now[F-1:0];
        pb     = item.data_phase_now[F-1:0];
        if (item.pilot_tow_now == item.data_tow_now)
        begin
            pa = item.pilot_phase_now[F-1:0];
            pb = item.data_phase_now[F-1:0];
        end
        else if (item.pilot_tow_now == item.data_tow_prev)
        begin
            pa = item.pilot_phase_now[F-1:0];
            pb = item.data_phase_prev[F-1:0];
        end
        else if (item.pilot_tow_prev == item.data_tow_now)
        begin
            pa = item.pilot_phase_prev[F-1:0];
            pb = item.data_phase_now[F-1:0];
        end
        else if (item.pilot_tow_prev == item.data_tow_prev)
        begin
            pa = item.pilot_phase_prev[F-1:0];
            pb = item.data_phase_prev[F-1:0];
        end
        else
        begin
            tmatch = 1'b0;
        end
    end

    // distance to the nearest whole cycle
    assign frac     = pa - pb;
    assign other    = (F + 1)'(1) << F;
    assign cyc_dist = ({1'b0, frac} < (other - {1'b0, frac})) ? {1'b0, frac}
                                                               : (other - {1'b0, frac});
    assign metric   = signed'(CMP_W'(cyc_dist));
    assign tol_s    = signed'(CMP_W'(tol_reg));

    always_comb
    begin
        if (metric < tol_s)
        begin
            found = POL_INVERTED;
        end
        else if (metric > HALF - tol_s)
        begin
            found = POL_NORMAL;
        end
        else
        begin
            found = POL_UNKNOWN;
        end
    end

    always_comb
    begin
        drop       = 1'b0;
        status     = ST_SKIPPED;
        pol        = POL_UNKNOWN;
        upd        = 1'b0;
        count_next = count_reg;
        sync_next  = sync_reg;
        if (item.epoch_valid)
        begin
            if (item.freq_locked)
            begin
                drop = 1'b1;
            end
            else if (!sync_reg)
            begin
                if (!item.partner_present || item.partner_synced)
                begin
                    drop = 1'b1;
                end
                else if (!tmatch)
                begin
                    count_next = '0;
                    status     = ST_NO_TIME;
                end
                else if (found == POL_UNKNOWN)
                begin
                    count_next = '0;
                    status     = ST_MISMATCH;
                end
                else
                begin
                    status = ST_MATCHED;
                    if (count_reg < limit_reg)
                    begin
                        count_next = count_reg + LIMIT_W'(1);
                    end
                    else
                    begin
                        sync_next = 1'b1;
                        pol       = found;
                        upd       = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sync_reg  <= 1'b0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
            sync_reg  <= sync_next;
        end
    end

    always_comb
    begin
        res.drop_request     = drop;
        res.check_status     = status;
        res.resolved         = sync_next;
        res.partner_polarity = pol;
        res.partner_update   = upd;
        res.match_count      = count_next;
    end

endmodule

@@ src/hcar_out_reg.sv @@
`timescale 1ns / 1ps

module hcar_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  hcar_pkg::res_t in_res,
    input  logic           out_stall,
    output logic           accept,
    output logic           out_valid,
    output hcar_pkg::res_t out_res
);
    import hcar_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign accept     = !valid_reg || !out_stall;
    assign valid_next = accept ? in_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the result while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (accept && in_valid)
        begin
            res_reg <= in_res;
        end
    end

endmodule

@@ src/half_cycle_ambiguity_resolver.sv @@
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in        in_valid / in_stall  epoch flags, phases, time tags, partner flags
// out       out_valid / out_stall drop, status, sync, polarity, update, count
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; a result is offered after
// acceptance once the item has passed the input register, then the result register.
// Sync and match count update as the item moves into the result register.
// rst_n clears valid flags and state and loads register defaults.
// An out_stall backs up through the result register to in_stall.

module half_cycle_ambiguity_resolver #(
    parameter int PHASE_FRAC_BITS = hcar_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    epoch_valid,
    input  logic                                    freq_locked,
    input  logic signed [hcar_pkg::PHASE_W-1:0]     pilot_phase_now,
    input  logic signed [hcar_pkg::PHASE_W-1:0]     pilot_phase_prev,
    input  logic signed [hcar_pkg::TOW_W-1:0]       pilot_tow_now,
    input  logic signed [hcar_pkg::TOW_W-1:0]       pilot_tow_prev,
    input  logic signed [hcar_pkg::PHASE_W-1:0]     data_phase_now,
    input  logic signed [hcar_pkg::PHASE_W-1:0]     data_phase_prev,
    input  logic signed [hcar_pkg::TOW_W-1:0]       data_tow_now,
    input  logic signed [hcar_pkg::TOW_W-1:0]       data_tow_prev,
    input  logic                                    partner_present,
    input  logic                                    partner_synced,

    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    drop_request,
    output logic [1:0]                              check_status,
    output logic                                    resolved,
    output logic [1:0]                              partner_polarity,
    output logic                                    partner_update,
    output logic [hcar_pkg::LIMIT_W-1:0]            match_count,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [hcar_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [hcar_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import hcar_pkg::*;

    item_t in_item;
    item_t s1_item;
    logic  s1_valid;
    logic  accept;
    logic  fire;
    res_t  eval_res;
    res_t  out_res;

    always_comb
    begin
        in_item.epoch_valid      = epoch_valid;
        in_item.freq_locked      = freq_locked;
        in_item.pilot_phase_now  = pilot_phase_now;
        in_item.pilot_phase_prev = pilot_phase_prev;
        in_item.pilot_tow_now    = pilot_tow_now;
        in_item.pilot_tow_prev   = pilot_tow_prev;
        in_item.data_phase_now   = data_phase_now;
        in_item.data_phase_prev  = data_phase_prev;
        in_item.data_tow_now     = data_tow_now;
        in_item.data_tow_prev    = data_tow_prev;
        in_item.partner_present  = partner_present;
        in_item.partner_synced   = partner_synced;
    end

    assign fire = s1_valid && accept;

    hcar_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_item  (in_item),
        .advance  (accept),
        .stall    (in_stall),
        .valid    (s1_valid),
        .item     (s1_item)
    );

    hcar_eval #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .fire      (fire),
        .item      (s1_item),
        .res       (eval_res)
    );

    hcar_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_res    (eval_res),
        .out_stall (out_stall),
        .accept    (accept),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign drop_request     = out_res.drop_request;
    assign check_status     = out_res.check_status;
    assign resolved         = out_res.resolved;
    assign partner_polarity = out_res.partner_polarity;
    assign partner_update   = out_res.partner_update;
    assign match_count      = out_res.match_count;

`ifndef SYNTH
    a_update_means_resolved: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && partner_update |-> resolved && check_status == ST_MATCHED)
        else $error("update without resolution");

    a_polarity_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && partner_update |->
            partner_polarity == POL_NORMAL || partner_polarity == POL_INVERTED)
        else $error("update without known polarity");

    a_no_polarity_otherwise: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !partner_update |-> partner_polarity == POL_UNKNOWN)
        else $error("polarity outside update");

    a_drop_is_skip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drop_request |-> check_status == ST_SKIPPED)
        else $error("drop with check status");
`endif

endmodule

@@ tb/half_cycle_ambiguity_resolver_test.sv @@
`timescale 1ns / 1ps

module half_cycle_ambiguity_resolver_test;

    import hcar_pkg::*;

    localparam int HALF_CYCLE = 1 << (FRAC_BITS_DEF - 1);
    localparam logic [TOW_W-1:0] TOW_MAX = 31'd604799999;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      epoch_valid = 1'b0;
    logic                      freq_locked = 1'b0;
    logic signed [PHASE_W-1:0] pilot_phase_now = '0;
    logic signed [PHASE_W-1:0] pilot_phase_prev = '0;
    logic signed [TOW_W-1:0]   pilot_tow_now = '0;
    logic signed [TOW_W-1:0]   pilot_tow_prev = '0;
    logic signed [PHASE_W-1:0] data_phase_now = '0;
    logic signed [PHASE_W-1:0] data_phase_prev = '0;
    logic signed [TOW_W-1:0]   data_tow_now = '0;
    logic signed [TOW_W-1:0]   data_tow_prev = '0;
    logic                      partner_present = 1'b0;
    logic                      partner_synced = 1'b0;

    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      drop_request;
    logic [1:0]                check_status;
    logic                      resolved;
    logic [1:0]                partner_polarity;
    logic                      partner_update;
    logic [LIMIT_W-1:0]        match_count;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    logic [TOL_W-1:0]   tolerance_setting = TOL_RESET;
    logic [LIMIT_W-1:0] limit_setting = LIMIT_RESET;
    logic [LIMIT_W-1:0] run_length = '0;
    logic               sync_declared = 1'b0;

    item_t epochs_to_send[$];
    res_t  verdicts_due[$];
    item_t held_epoch;
    int    send_gap = 0;
    int    send_burst = 0;
    int    recv_wait = 0;
    int    recv_burst = 0;
    int    fail_count = 0;

    half_cycle_ambiguity_resolver i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .epoch_valid      (epoch_valid),
        .freq_locked      (freq_locked),
        .pilot_phase_now  (pilot_phase_now),
        .pilot_phase_prev (pilot_phase_prev),
        .pilot_tow_now    (pilot_tow_now),
        .pilot_tow_prev   (pilot_tow_prev),
        .data_phase_now   (data_phase_now),
        .data_phase_prev  (data_phase_prev),
        .data_tow_now     (data_tow_now),
        .data_tow_prev    (data_tow_prev),
        .partner_present  (partner_present),
        .partner_synced   (partner_synced),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drop_request     (drop_request),
        .check_status     (check_status),
        .resolved         (resolved),
        .partner_polarity (partner_polarity),
        .partner_update   (partner_update),
        .match_count      (match_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic res_t judge_epoch(item_t e);
        res_t               r;
        logic [PHASE_W-1:0] pa;
        logic [PHASE_W-1:0] pb;
        logic [PHASE_W-1:0] diff;
        logic [FRAC_BITS_DEF:0] frac;
        logic [FRAC_BITS_DEF:0] other;
        int                 cyc_dist;
        logic [1:0]         found;
        logic               paired;
        r = '0;
        r.check_status = ST_SKIPPED;
        r.partner_polarity = POL_UNKNOWN;
        paired = 1'b1;
        pa = '0;
        pb = '0;
        if (e.epoch_valid) begin
            if (e.freq_locked) begin
                r.drop_request = 1'b1;
            end
            else if (!sync_declared) begin
                if (!e.partner_present || e.partner_synced) begin
                    r.drop_request = 1'b1;
                end
                else begin
                    if (e.pilot_tow_now == e.data_tow_now) begin
                        pa = e.pilot_phase_now;
                        pb = e.data_phase_now;
                    end
                    else if (e.pilot_tow_now == e.data_tow_prev) begin
                        pa = e.pilot_phase_now;
                        pb = e.data_phase_prev;
                    end
                    else if (e.pilot_tow_prev == e.data_tow_now) begin
                        pa = e.pilot_phase_prev;
                        pb = e.data_phase_now;
                    end
                    else if (e.pilot_tow_prev == e.data_tow_prev) begin
                        pa = e.pilot_phase_prev;
                        pb = e.data_phase_prev;
                    end
                    else begin
                        paired = 1'b0;
                    end
                    if (!paired) begin
                        run_length = '0;
                        r.check_status = ST_NO_TIME;
                    end
                    else begin
                        diff = pa - pb;
                        frac = {1'b0, diff[FRAC_BITS_DEF-1:0]};
                        other = (FRAC_BITS_DEF + 1)'((1 << FRAC_BITS_DEF) - int'(frac));
                        cyc_dist = int'((frac < other) ? frac : other);
                        found = POL_UNKNOWN;
                        if (cyc_dist < int'(tolerance_setting))
                            found = POL_INVERTED;
                        else if (cyc_dist > HALF_CYCLE - int'(tolerance_setting))
                            found = POL_NORMAL;
                        if (found == POL_UNKNOWN) begin
                            run_length = '0;
                            r.check_status = ST_MISMATCH;
                        end
                        else begin
                            r.check_status = ST_MATCHED;
                            if (run_length < limit_setting) begin
                                run_length = run_length + LIMIT_W'(1);
                            end
                            else begin
                                sync_declared = 1'b1;
                                r.partner_polarity = found;
                                r.partner_update = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        r.resolved = sync_declared;
        r.match_count = run_length;
        return r;
    endfunction

    function automatic logic [TOW_W-1:0] rand_tag();
        if ($urandom_range(0, 31) == 0)
            return '1;
        return TOW_W'($urandom_range(0, 604799999));
    endfunction

    function automatic logic [PHASE_W-1:0] rand_phase();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0:       return {1'b0, {(PHASE_W-1){1'b1}}};
            1:       return {1'b1, {(PHASE_W-1){1'b0}}};
            default: return r[PHASE_W-1:0];
        endcase
    endfunction

    function automatic int pick_distance(bit want_match);
        int tol;
        int lo;
        tol = int'(tolerance_setting);
        lo = HALF_CYCLE - tol + 1;
        if (lo < 0)
            lo = 0;
        case (want_match ? $urandom_range(0, 1) : $urandom_range(2, 5))
            0:       return (tol > 0) ? $urandom_range(0, tol - 1) : 0;
            1:       return (lo <= HALF_CYCLE) ? $urandom_range(lo, HALF_CYCLE) : HALF_CYCLE;
            2:       return (tol > HALF_CYCLE) ? HALF_CYCLE : tol;
            3:       return (HALF_CYCLE - tol < 0) ? 0 : HALF_CYCLE - tol;
            4:       return HALF_CYCLE;
            default: return $urandom_range(0, HALF_CYCLE);
        endcase
    endfunction

    // Tag pair `pair` agrees and its phases sit `cyc_dist` LSBs from a whole cycle.
    function automatic item_t make_epoch(int pair, int cyc_dist);
        item_t                  e;
        logic [PHASE_W-1:0]     delta;
        logic [FRAC_BITS_DEF:0] frac;
        logic [31:0]            whole;
        frac = (FRAC_BITS_DEF + 1)'($urandom_range(0, 1) ? cyc_dist
                                                          : (1 << FRAC_BITS_DEF) - cyc_dist);
        whole = $urandom;
        delta = {whole, frac[FRAC_BITS_DEF-1:0]};
        e.epoch_valid = 1'b1;
        e.freq_locked = 1'b0;
        e.partner_present = 1'b1;
        e.partner_synced = 1'b0;
        e.pilot_phase_now = rand_phase();
        e.pilot_phase_prev = rand_phase();
        e.data_phase_now = rand_phase();
        e.data_phase_prev = rand_phase();
        e.pilot_tow_now = rand_tag();
        e.pilot_tow_prev = rand_tag();
        e.data_tow_now = rand_tag();
        e.data_tow_prev = rand_tag();
        case (pair)
            0: begin
                e.data_tow_now = e.pilot_tow_now;
                e.data_phase_now = e.pilot_phase_now - delta;
            end
            1: begin
                e.data_tow_prev = e.pilot_tow_now;
                e.data_phase_prev = e.pilot_phase_now - delta;
            end
            2: begin
                e.data_tow_now = e.pilot_tow_prev;
                e.data_phase_now = e.pilot_phase_prev - delta;
            end
            default: begin
                e.data_tow_prev = e.pilot_tow_prev;
                e.data_phase_prev = e.pilot_phase_prev - delta;
            end
        endcase
        return e;
    endfunction

    function automatic item_t gen_epoch(int clean_pct);
        item_t            e;
        logic [TOW_W-1:0] ta;
        logic [TOW_W-1:0] tb;
        logic [3:0]       flags;
        e = make_epoch($urandom_range(0, 3), pick_distance($urandom_range(0, 9) != 0));
        if ($urandom_range(1, 100) > clean_pct) begin
            ta = rand_tag();
            tb = rand_tag();
            flags = 4'($urandom);
            case ($urandom_range(0, 5))
                0: e.epoch_valid = 1'b0;
                1: e.freq_locked = 1'b1;
                2: e.partner_present = 1'b0;
                3: e.partner_synced = 1'b1;
                4: begin
                    e.data_tow_now = ta;
                    e.data_tow_prev = tb;
                end
                default: begin
                    {e.epoch_valid, e.freq_locked, e.partner_present, e.partner_synced} = flags;
                    e.pilot_tow_now = $urandom_range(0, 1) ? ta : tb;
                    e.pilot_tow_prev = $urandom_range(0, 1) ? ta : tb;
                    e.data_tow_now = $urandom_range(0, 1) ? ta : tb;
                    e.data_tow_prev = $urandom_range(0, 1) ? ta : tb;
                end
            endcase
        end
        return e;
    endfunction

    task automatic draw_wait(inout int burst, output int cycles);
        if (burst > 0) begin
            burst--;
            cycles = 0;
        end
        else if ($urandom_range(0, 24) == 0) begin
            burst = $urandom_range(10, 50);
            cycles = 0;
        end
        else begin
            cycles = $urandom_range(0, 16);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PHASE_TOL)
            tolerance_setting = value[TOL_W-1:0];
        else if (idx == REG_MATCH_LIMIT)
            limit_setting = value[LIMIT_W-1:0];
        @(posedge clk);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (epochs_to_send.size() != 0 || in_valid || verdicts_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Driver: advance to the next item once the current one is taken and its gap has run out
    always @(posedge clk) begin
        logic valid_next;
        valid_next = in_valid;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                verdicts_due.push_back(judge_epoch(held_epoch));
                valid_next = 1'b0;
                draw_wait(send_burst, send_gap);
            end
            if (!valid_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end
                else if (epochs_to_send.size() != 0) begin
                    held_epoch = epochs_to_send.pop_front();
                    epoch_valid <= held_epoch.epoch_valid;
                    freq_locked <= held_epoch.freq_locked;
                    pilot_phase_now <= held_epoch.pilot_phase_now;
                    pilot_phase_prev <= held_epoch.pilot_phase_prev;
                    pilot_tow_now <= held_epoch.pilot_tow_now;
                    pilot_tow_prev <= held_epoch.pilot_tow_prev;
                    data_phase_now <= held_epoch.data_phase_now;
                    data_phase_prev <= held_epoch.data_phase_prev;
                    data_tow_now <= held_epoch.data_tow_now;
                    data_tow_prev <= held_epoch.data_tow_prev;
                    partner_present <= held_epoch.partner_present;
                    partner_synced <= held_epoch.partner_synced;
                    valid_next = 1'b1;
                end
            end
        end
        in_valid <= valid_next;
    end

    // Monitor: compare each taken item against the oldest verdict, then hold off
    always @(posedge clk) begin
        res_t want;
        logic stall_next;
        stall_next = 1'b0;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: result expected none, got status %0d count %0d",
                             $time, check_status, match_count);
                    fail_count++;
                end
                else begin
                    want = verdicts_due.pop_front();
                    check_field("drop_request", 8'(want.drop_request), 8'(drop_request));
                    check_field("check_status", 8'(want.check_status), 8'(check_status));
                    check_field("resolved", 8'(want.resolved), 8'(resolved));
                    check_field("partner_polarity", 8'(want.partner_polarity),
                                8'(partner_polarity));
                    check_field("partner_update", 8'(want.partner_update),
                                8'(partner_update));
                    check_field("match_count", want.match_count, match_count);
                end
                draw_wait(recv_burst, recv_wait);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                stall_next = 1'b1;
            end
        end
        out_stall <= stall_next;
    end

    initial begin
        #2_000_000;
        $display("half_cycle_ambiguity_resolver_test failed");
        $finish;
    end

    initial begin
        item_t e;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        @(negedge clk);
        e = make_epoch(0, 0);
        e.epoch_valid = 1'b0;
        epochs_to_send.push_back(e);
        e = make_epoch(0, 0);
        e.freq_locked = 1'b1;
        epochs_to_send.push_back(e);
        e = make_epoch(1, 0);
        e.partner_present = 1'b0;
        epochs_to_send.push_back(e);
        e = make_epoch(2, 0);
        e.partner_synced = 1'b1;
        epochs_to_send.push_back(e);
        epochs_to_send.push_back(make_epoch(0, 0));
        epochs_to_send.push_back(make_epoch(1, HALF_CYCLE));
        epochs_to_send.push_back(make_epoch(2, int'(TOL_RESET) - 1));
        epochs_to_send.push_back(make_epoch(3, HALF_CYCLE - int'(TOL_RESET) + 1));
        epochs_to_send.push_back(make_epoch(0, int'(TOL_RESET)));
        epochs_to_send.push_back(make_epoch(3, HALF_CYCLE - int'(TOL_RESET)));
        e = make_epoch(0, 0);
        e.pilot_tow_now = 31'd0;
        e.pilot_tow_prev = 31'd1;
        e.data_tow_now = TOW_MAX;
        e.data_tow_prev = 31'd2;
        epochs_to_send.push_back(e);
        e = make_epoch(0, 0);
        {e.pilot_tow_now, e.pilot_tow_prev, e.data_tow_now, e.data_tow_prev} = '1;
        epochs_to_send.push_back(e);
        e = make_epoch(0, 1);
        {e.pilot_tow_now, e.pilot_tow_prev, e.data_tow_now, e.data_tow_prev} = {4{TOW_MAX}};
        epochs_to_send.push_back(e);
        e = make_epoch(2, 5);
        e.data_tow_prev = e.pilot_tow_prev;
        epochs_to_send.push_back(e);
        e = make_epoch(0, 0);
        e.pilot_phase_now = {1'b0, {(PHASE_W-1){1'b1}}};
        e.data_phase_now = {1'b1, {(PHASE_W-1){1'b0}}};
        epochs_to_send.push_back(e);
        e = make_epoch(3, 0);
        e.pilot_phase_prev = {1'b1, {(PHASE_W-1){1'b0}}};
        e.data_phase_prev = {1'b0, {(PHASE_W-1){1'b1}}};
        epochs_to_send.push_back(e);
        repeat (5) epochs_to_send.push_back(make_epoch($urandom_range(0, 3), pick_distance(1'b1)));
        e = make_epoch(0, 0);
        e.freq_locked = 1'b1;
        epochs_to_send.push_back(e);
        e = make_epoch(1, 0);
        e.epoch_valid = 1'b0;
        e.freq_locked = 1'b1;
        epochs_to_send.push_back(e);
        wait_idle();

        write_reg(REG_PHASE_TOL, CFG_DATA_W'($urandom_range(1, 32767)));
        write_reg(REG_MATCH_LIMIT, 16'd255);
        @(negedge clk);
        repeat (300) epochs_to_send.push_back(gen_epoch(95));
        wait_idle();

        // nothing can match with a zero window, so a zero limit is safe here
        write_reg(REG_PHASE_TOL, 16'd0);
        write_reg(REG_MATCH_LIMIT, 16'd0);
        @(negedge clk);
        repeat (150) epochs_to_send.push_back(gen_epoch(80));
        wait_idle();

        write_reg(REG_PHASE_TOL, 16'd32768);
        write_reg(REG_MATCH_LIMIT, 16'd255);
        @(negedge clk);
        repeat (200) epochs_to_send.push_back(gen_epoch(90));
        wait_idle();

        write_reg(REG_PHASE_TOL, CFG_DATA_W'($urandom_range(1, 32767)));
        @(negedge clk);
        repeat (250) epochs_to_send.push_back(make_epoch($urandom_range(0, 3), pick_distance(1'b1)));
        wait_idle();

        write_reg(REG_PHASE_TOL, CFG_DATA_W'($urandom_range(1, 32768)));
        write_reg(REG_MATCH_LIMIT,
                  CFG_DATA_W'($urandom_range(0, 1) ? 0 : $urandom_range(1, 40)));
        @(negedge clk);
        e = make_epoch(0, 0);
        e.pilot_tow_now = 31'd0;
        e.pilot_tow_prev = 31'd1;
        e.data_tow_now = 31'd2;
        e.data_tow_prev = 31'd3;
        epochs_to_send.push_back(e);
        repeat (426) epochs_to_send.push_back(gen_epoch(90));
        wait_idle();

        repeat (8) @(posedge clk);
        if (fail_count == 0 && verdicts_due.size() == 0)
            $display("half_cycle_ambiguity_resolver_test passed");
        else
            $display("half_cycle_ambiguity_resolver_test failed");
        $finish;
    end

endmodule
